FILE: sv/irc_tok_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// irc_tok_pkg
// Shared types and constants of the IRC line tokenizer.
// ----------------------------------------------------------------------------
package irc_tok_pkg;

  localparam int unsigned LineLengthDef = 512;
  localparam int unsigned MaxParamsDef  = 255;
  localparam logic [9:0]  NumericMaxRst = 10'd999;

  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic [2:0] CmdDigits = 3'd3;
  localparam logic [2:0] CmdCountSat = 3'd4;

  typedef enum logic [7:0] {
    PhLineStart = 8'b0000_0001,
    PhPrefixGap = 8'b0000_0010,
    PhPrefix    = 8'b0000_0100,
    PhCmdGap    = 8'b0000_1000,
    PhCommand   = 8'b0001_0000,
    PhParamGap  = 8'b0010_0000,
    PhMiddle    = 8'b0100_0000,
    PhTrailing  = 8'b1000_0000
  } phase_e;

  typedef enum logic [2:0] {
    KindPrefix   = 3'd0,
    KindCommand  = 3'd1,
    KindMiddle   = 3'd2,
    KindTrailing = 3'd3,
    KindDropped  = 3'd4
  } kind_e;

  typedef struct packed {
    logic       known;
    logic       is_num;
    logic [9:0] value;
  } cmd_info_t;

  typedef struct packed {
    kind_e      kind;
    logic [8:0] start;
    logic [9:0] length;
    logic [7:0] pidx;
    cmd_info_t  info;
    logic       ovf;
    logic       eol;
  } token_t;

  // Classify the finished command word.
  function automatic cmd_info_t latch_cmd(logic [9:0] acc, logic [2:0] dcnt,
                                          logic all_dig, logic [9:0] nmax);
    cmd_info_t r;
    r.is_num = (dcnt == CmdDigits) && all_dig;
    r.value  = r.is_num ? acc : 10'd0;
    r.known  = r.is_num && (r.value != 10'd0) && (r.value <= nmax);
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/irc_tok_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// irc_tok_in_if
// Byte channel into the tokenizer: one line character per transaction.
// ----------------------------------------------------------------------------
interface irc_tok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       line_last;

  modport source (output valid, line_byte, line_last, input ready);
  modport sink   (input valid, line_byte, line_last, output ready);
endinterface
`default_nettype wire

FILE: sv/irc_tok_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// irc_tok_out_if
// Token channel out of the tokenizer: one token per transaction.
// ----------------------------------------------------------------------------
interface irc_tok_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_kind;
  logic [8:0] token_start;
  logic [9:0] token_length;
  logic [7:0] param_index;
  logic [9:0] command_numeric;
  logic       command_is_numeric;
  logic       numeric_known;
  logic       param_overflow;
  logic       end_of_line;

  modport source (output valid, token_kind, token_start, token_length, param_index,
                  command_numeric, command_is_numeric, numeric_known,
                  param_overflow, end_of_line, input ready);
  modport sink   (input valid, token_kind, token_start, token_length, param_index,
                  command_numeric, command_is_numeric, numeric_known,
                  param_overflow, end_of_line, output ready);
endinterface
`default_nettype wire

FILE: sv/irc_line_tokenizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// irc_line_tokenizer
// Splits an IRC message line, one byte per transaction, into tokens.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  line_i    in   valid/ready    line_byte, line_last
//  token_o   out  valid/ready    kind, start, length, index, command info, eol
//  cfg       in   cfg_we_i       cfg_wdata_i = numeric_max
//
// One byte is parsed per cycle; its tokens (zero, one or two) go into a
// four-entry output queue and show on token_o from the next cycle. The queue
// drains one token per cycle: line_i is ready while it has room for two
// tokens, so only bytes that end two tokens in close succession, or a stalled
// token_o, hold line_i. Reset returns the parser to line start and
// numeric_max to 999; the queue comes up empty.
module irc_line_tokenizer
  import irc_tok_pkg::*;
#(
  parameter int unsigned LINE_LENGTH = LineLengthDef,
  parameter int unsigned MAX_PARAMS  = MaxParamsDef
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  irc_tok_in_if.sink        line_i,
  irc_tok_out_if.source     token_o,
  input  wire               cfg_we_i,
  input  wire  [9:0]        cfg_wdata_i
);

  localparam int unsigned OffW = $clog2(LINE_LENGTH + 1);

  // Parser state
  phase_e          phase_q, phase_d;
  logic [OffW-1:0] off_q, off_d;
  logic [OffW-1:0] start_q, start_d;
  logic [7:0]      pcnt_q, pcnt_d;
  logic [9:0]      acc_q, acc_d;
  logic [2:0]      dcnt_q, dcnt_d;
  logic            alld_q, alld_d;
  cmd_info_t       info_q, info_d;
  logic [9:0]      nmax_q;

  // Output queue
  token_t          fifo_q [4];
  logic [1:0]      wr_ptr_q, rd_ptr_q;
  logic [2:0]      cnt_q;

  token_t          res [2];
  logic [1:0]      n_res;
  logic            in_fire, out_fire;

  assign line_i.ready = (cnt_q <= 3'd2);
  assign in_fire      = line_i.valid && line_i.ready;
  assign out_fire     = token_o.valid && token_o.ready;

  function automatic token_t mk_tok(kind_e kind, logic [15:0] start, logic [15:0] len,
                                    logic [7:0] pidx, cmd_info_t info, logic ovf);
    token_t t;
    t.kind   = kind;
    t.start  = start[8:0];
    t.length = len[9:0];
    t.pidx   = pidx;
    t.info   = info;
    t.ovf    = ovf;
    t.eol    = 1'b0;
    return t;
  endfunction

  always_comb begin
    logic [7:0]      b;
    logic            digit;
    logic            ovf;
    logic [7:0]      pidx;
    logic [OffW-1:0] len;

    phase_d = phase_q;
    off_d   = off_q;
    start_d = start_q;
    pcnt_d  = pcnt_q;
    acc_d   = acc_q;
    dcnt_d  = dcnt_q;
    alld_d  = alld_q;
    info_d  = info_q;
    res[0]  = '0;
    res[1]  = '0;
    n_res   = 2'd0;
    b       = line_i.line_byte;
    digit   = b inside {[ChZero:ChNine]};
    ovf     = 1'b0;
    pidx    = 8'd0;
    len     = '0;

    if (in_fire) begin
      if (off_q < OffW'(LINE_LENGTH)) begin
        off_d = off_q + 1'b1;
        case (phase_q)
          PhLineStart, PhCmdGap: begin
            if (phase_q == PhLineStart && b == ChColon) begin
              phase_d = PhPrefixGap;
            end else if (b == ChSpace) begin
              phase_d = PhCmdGap;
            end else begin
              // open the command; first character counts
              start_d = off_q;
              phase_d = PhCommand;
              alld_d  = digit;
              acc_d   = digit ? {6'd0, 4'(b - ChZero)} : 10'd0;
              dcnt_d  = 3'd1;
            end
          end
          PhPrefixGap: begin
            if (b != ChSpace) begin
              start_d = off_q;
              phase_d = PhPrefix;
            end
          end
          PhPrefix: begin
            if (b == ChSpace) begin
              res[0]  = mk_tok(KindPrefix, 16'(start_q), 16'(off_q - start_q), 8'd0,
                               '0, 1'b0);
              n_res   = 2'd1;
              phase_d = PhCmdGap;
            end
          end
          PhCommand: begin
            if (b == ChSpace) begin
              info_d  = latch_cmd(acc_q, dcnt_q, alld_q, nmax_q);
              res[0]  = mk_tok(KindCommand, 16'(start_q), 16'(off_q - start_q), 8'd0,
                               info_d, 1'b0);
              n_res   = 2'd1;
              phase_d = PhParamGap;
            end else begin
              if (digit && dcnt_q < CmdDigits) begin
                acc_d = 10'((acc_q << 3) + (acc_q << 1) + {6'd0, 4'(b - ChZero)});
              end
              if (!digit) begin
                alld_d = 1'b0;
              end
              if (dcnt_q < CmdCountSat) begin
                dcnt_d = dcnt_q + 3'd1;
              end
            end
          end
          PhParamGap: begin
            if (b == ChColon) begin
              start_d = off_q + 1'b1;
              phase_d = PhTrailing;
            end else if (b != ChSpace) begin
              start_d = off_q;
              phase_d = PhMiddle;
            end
          end
          PhMiddle: begin
            if (b == ChSpace) begin
              ovf     = (pcnt_q >= 8'(MAX_PARAMS));
              pidx    = ovf ? 8'(MAX_PARAMS) : pcnt_q;
              pcnt_d  = ovf ? pcnt_q : pcnt_q + 8'd1;
              res[0]  = mk_tok(KindMiddle, 16'(start_q), 16'(off_q - start_q), pidx,
                               info_q, ovf);
              n_res   = 2'd1;
              phase_d = PhParamGap;
            end
          end
          default: ;
        endcase
      end

      if (line_i.line_last) begin
        len  = (off_d >= start_d) ? off_d - start_d : '0;
        ovf  = (pcnt_d >= 8'(MAX_PARAMS));
        pidx = ovf ? 8'(MAX_PARAMS) : pcnt_d;
        case (phase_d)
          PhPrefix: begin
            res[0] = mk_tok(KindPrefix, 16'(start_d), 16'(len), 8'd0, '0, 1'b0);
            res[1] = mk_tok(KindDropped, 16'd0, 16'd0, 8'd0, '0, 1'b0);
            n_res  = 2'd2;
          end
          PhCommand: begin
            info_d = latch_cmd(acc_d, dcnt_d, alld_d, nmax_q);
            res[0] = mk_tok(KindCommand, 16'(start_d), 16'(len), 8'd0, info_d, 1'b0);
            res[1] = mk_tok(KindMiddle, 16'(off_d), 16'd0, pidx, info_d, ovf);
            n_res  = 2'd2;
          end
          PhParamGap: begin
            res[n_res[0]] = mk_tok(KindMiddle, 16'(off_d), 16'd0, pidx, info_d, ovf);
            n_res         = n_res + 2'd1;
          end
          PhMiddle: begin
            res[n_res[0]] = mk_tok(KindMiddle, 16'(start_d), 16'(len), pidx, info_d, ovf);
            n_res         = n_res + 2'd1;
          end
          PhTrailing: begin
            res[n_res[0]] = mk_tok(KindTrailing, 16'(start_d), 16'(len), pidx, info_d,
                                   ovf);
            n_res         = n_res + 2'd1;
          end
          default: begin
            res[n_res[0]] = mk_tok(KindDropped, 16'd0, 16'd0, 8'd0, '0, 1'b0);
            n_res         = n_res + 2'd1;
          end
        endcase
        // flag the final token, then clear the line
        if (n_res == 2'd2) begin
          res[1].eol = 1'b1;
        end else begin
          res[0].eol = 1'b1;
        end
        phase_d = PhLineStart;
        off_d   = '0;
        start_d = '0;
        pcnt_d  = 8'd0;
        acc_d   = 10'd0;
        dcnt_d  = 3'd0;
        alld_d  = 1'b1;
        info_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhLineStart;
      off_q    <= '0;
      start_q  <= '0;
      pcnt_q   <= 8'd0;
      acc_q    <= 10'd0;
      dcnt_q   <= 3'd0;
      alld_q   <= 1'b1;
      info_q   <= '0;
      nmax_q   <= NumericMaxRst;
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      cnt_q    <= 3'd0;
    end else begin
      phase_q  <= phase_d;
      off_q    <= off_d;
      start_q  <= start_d;
      pcnt_q   <= pcnt_d;
      acc_q    <= acc_d;
      dcnt_q   <= dcnt_d;
      alld_q   <= alld_d;
      info_q   <= info_d;
      if (cfg_we_i) begin
        nmax_q <= cfg_wdata_i;
      end
      wr_ptr_q <= wr_ptr_q + n_res;
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      cnt_q    <= cnt_q + {1'b0, n_res} - {2'd0, out_fire};
    end
  end

  // Queue payload: no reset needed
  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) begin
      fifo_q[wr_ptr_q] <= res[0];
    end
    if (n_res == 2'd2) begin
      fifo_q[wr_ptr_q + 2'd1] <= res[1];
    end
  end

  assign token_o.valid              = (cnt_q != 3'd0);
  assign token_o.token_kind         = fifo_q[rd_ptr_q].kind;
  assign token_o.token_start        = fifo_q[rd_ptr_q].start;
  assign token_o.token_length       = fifo_q[rd_ptr_q].length;
  assign token_o.param_index        = fifo_q[rd_ptr_q].pidx;
  assign token_o.command_numeric    = fifo_q[rd_ptr_q].info.value;
  assign token_o.command_is_numeric = fifo_q[rd_ptr_q].info.is_num;
  assign token_o.numeric_known      = fifo_q[rd_ptr_q].info.known;
  assign token_o.param_overflow     = fifo_q[rd_ptr_q].ovf;
  assign token_o.end_of_line        = fifo_q[rd_ptr_q].eol;

endmodule
`default_nettype wire
